### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/qss_pkg.sv
// Shared record type and field widths for the queue-to-stack sorter.
package qss_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int REC_W = KEY_W + TAG_W;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } rec_t;

endpackage

### hdl/qss_ram.sv
// Record memory with one write port and one registered read port.
module qss_ram
  import qss_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rec_t                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rec_t                     rdata
);

  rec_t mem [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/queue_to_stack_sort.sv
// Batch sorter: records enter a FIFO, are sorted through a stack, then leave in key order.
// Load: one record per cycle, in_tready high while loading.
// Sort: each FIFO head is read (S_HWAIT, S_HEAD) and compared (S_CMP); each stack record moved back
//   to the queue passes S_CMP and S_PWAIT and heads again later; comparator and ports are shared.
// Emit: a new record is registered only after the last one is taken; the next batch loads while the last one waits.
// Reset (rst_n low, synchronous): FIFO, stack and drop flag empty, no output valid.
module queue_to_stack_sort
  import qss_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [REC_W-1:0]     in_tdata,   // item_key[31:0], item_tag[47:32]
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [REC_W-1:0]     out_tdata,  // out_key[31:0], out_tag[47:32]
  output logic                 out_tlast,
  output logic                 out_tuser   // overflowed[0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] HEAD_MAX = AW'(DEPTH - 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_HWAIT = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_PWAIT = 3'd5;
  localparam logic [2:0] S_EWAIT = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] height_r, height_nxt;
  logic          drop_r, drop_nxt;
  logic          out_valid_r, out_valid_nxt;
  rec_t          hrec_r, hrec_nxt;
  rec_t          out_rec_r, out_rec_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          fifo_we;
  rec_t          fifo_wdata;
  rec_t          fifo_q;
  logic          stack_we;
  rec_t          stack_wdata;
  rec_t          stack_q;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [CW-1:0] height_dec;
  rec_t          in_rec;

  assign in_rec.key = in_tdata[KEY_W-1:0];
  assign in_rec.tag = in_tdata[REC_W-1:KEY_W];

  assign tail_sum   = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail       = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign height_dec = height_r - 1'b1;

  qss_ram #(.DEPTH(DEPTH)) u_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (fifo_wdata),
    .raddr (head_r),
    .rdata (fifo_q)
  );

  qss_ram #(.DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (height_r[AW-1:0]),
    .wdata (stack_wdata),
    .raddr (height_dec[AW-1:0]),
    .rdata (stack_q)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    height_nxt    = height_r;
    drop_nxt      = drop_r;
    hrec_nxt      = hrec_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    fifo_we       = 1'b0;
    fifo_wdata    = in_rec;
    stack_we      = 1'b0;
    stack_wdata   = hrec_r;
    case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (count_r == DEPTH_C) begin
            drop_nxt = 1'b1;
          end else begin
            fifo_we   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (count_r == '0) begin
          state_nxt = S_LOAD;
          head_nxt  = '0;
          drop_nxt  = 1'b0;
        end else begin
          state_nxt = S_HWAIT;
        end
      end
      S_HWAIT: begin
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        hrec_nxt  = fifo_q;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (height_r != '0 && hrec_r.key > stack_q.key) begin
          fifo_we    = 1'b1;
          fifo_wdata = stack_q;
          count_nxt  = count_r + 1'b1;
          height_nxt = height_dec;
          state_nxt  = S_PWAIT;
        end else begin
          stack_we   = 1'b1;
          height_nxt = height_r + 1'b1;
          head_nxt   = (head_r == HEAD_MAX) ? '0 : head_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          state_nxt  = (count_r == CW'(1)) ? S_EWAIT : S_HWAIT;
        end
      end
      S_PWAIT: begin
        state_nxt = S_CMP;
      end
      S_EWAIT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_rec_nxt   = stack_q;
          out_last_nxt  = (height_r == CW'(1));
          out_ovf_nxt   = drop_r;
          height_nxt    = height_dec;
          if (height_r == CW'(1)) begin
            state_nxt = S_LOAD;
            head_nxt  = '0;
            count_nxt = '0;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      head_r      <= '0;
      count_r     <= '0;
      height_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      height_r    <= height_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hrec_r     <= hrec_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rec_r.tag, out_rec_r.key};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

### hdl/qss_checker.sv
// Port-level checks for the queue-to-stack sorter, bound to the top level.
`include "assert_macros.svh"

module qss_checker
  import qss_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tlast,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [REC_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser
);

  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "output valid right after reset")
  `ASSERT_CLK(a_last_starts_sort, clk, rst_n, in_tvalid && in_tready && in_tlast |=> !in_tready, "input taken after final record")
  `ASSERT_CLK(a_run_blocks_load, clk, rst_n, out_tvalid && out_tready && !out_tlast |=> !in_tready, "input taken mid run")
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable({out_tuser, out_tlast, out_tdata}), "stalled output changed")

endmodule

bind queue_to_stack_sort qss_checker u_qss_checker (.*);
